// ===== hdl/ssdfb_pkg.sv =====
`default_nettype none

package ssdfb_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int FRAME_LEN   = DIGIT_COUNT + 1;
    localparam int IDX_W       = $clog2(FRAME_LEN);

    localparam logic [7:0] BYTE_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] BYTE_WRITE_AUTO  = 8'h40;
    localparam logic [7:0] BYTE_DISPLAY_ON  = 8'h8F;
    localparam logic [7:0] BYTE_ADDR_START  = 8'hC0;
    localparam logic [7:0] SEG_DASH         = 8'h40;
    localparam logic [7:0] SEG_BLANK        = 8'h00;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_A           = 8'h41;
    localparam logic [7:0] CHAR_L           = 8'h4C;
    localparam logic [7:0] CHAR_GLYPH_BASE  = 8'h37;

    localparam logic signed [15:0] NUM_LIMIT = 16'sd999;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_NUMBER = 2'd1,
        CMD_TEXT   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]                          command;
        logic signed [15:0]                  value;
        logic [DIGIT_COUNT-1:0][7:0]         chars;
    } t_item;

    typedef struct packed {
        logic                                init;
        logic [FRAME_LEN-1:0][7:0]           data;
    } t_frame;

    function automatic logic [7:0] glyph_of(input logic [4:0] idx);
        logic [7:0] g;
        unique case (idx)
            5'd0:    g = 8'h3F;
            5'd1:    g = 8'h06;
            5'd2:    g = 8'h5B;
            5'd3:    g = 8'h4F;
            5'd4:    g = 8'h66;
            5'd5:    g = 8'h6D;
            5'd6:    g = 8'h7D;
            5'd7:    g = 8'h07;
            5'd8:    g = 8'h7F;
            5'd9:    g = 8'h6F;
            5'd10:   g = 8'h77;
            5'd11:   g = 8'h7C;
            5'd12:   g = 8'h39;
            5'd13:   g = 8'h5E;
            5'd14:   g = 8'h79;
            5'd15:   g = 8'h71;
            5'd16:   g = 8'h76;
            5'd17:   g = 8'h38;
            5'd18:   g = 8'h37;
            5'd19:   g = 8'h3E;
            5'd20:   g = 8'h73;
            5'd21:   g = 8'h5C;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/seven_segment_display_frame_builder_core.sv =====
// Path: a command is held in the encoder's input register, then loaded into the
// serialiser's frame register once it is free; the first word is presented from there.
// Throughput: one word per cycle while the output is ready; a number or text command is
// sent as five words and an init command as three, by the output serialiser.
// A new command is accepted while the previous one is still being sent.
// Reset is synchronous and active low; it clears the valid flags and the word index.
`default_nettype none

module seven_segment_display_frame_builder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // value[15:0], char_first[23:16], char_second[31:24], char_third[39:32],
    // char_fourth[47:40]
    input  wire logic [47:0] i_s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // frame_byte[7:0]
    output logic [7:0]       o_m_axis_tdata,
    // frame_begin[0], frame_end[1]
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import ssdfb_pkg::*;

    t_item   item;
    t_frame  frame;
    logic    load;
    logic    frame_free;
    logic    word_begin;
    logic    word_end;

    assign item.command = i_s_axis_tuser;
    assign item.value   = signed'(i_s_axis_tdata[15:0]);
    assign item.chars   = i_s_axis_tdata[47:16];

    ssdfb_encode u_encode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_item       (item),
        .o_ready      (o_s_axis_tready),
        .i_frame_free (frame_free),
        .o_load       (load),
        .o_frame      (frame)
    );

    ssdfb_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_frame (frame),
        .o_free  (frame_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_begin (word_begin),
        .o_end   (word_end),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {word_end, word_begin};

endmodule

`default_nettype wire

// ===== hdl/ssdfb_encode.sv =====
`default_nettype none

module ssdfb_encode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ssdfb_pkg::t_item   i_item,
    output logic                    o_ready,
    input  wire logic               i_frame_free,
    output logic                    o_load,
    output ssdfb_pkg::t_frame       o_frame
);
    import ssdfb_pkg::*;

    logic              r_valid;
    t_item             r_item;
    logic              cmd_known;
    logic              advance;

    logic signed [15:0] v_sat;
    logic signed [15:0] v_neg;
    logic              neg;
    logic [9:0]        mag;
    logic [15:0]       h_prod;
    logic [3:0]        dig_h;
    logic [9:0]        rem10;
    logic [6:0]        rem;
    logic [13:0]       t_prod;
    logic [3:0]        dig_t;
    logic [6:0]        one7;
    logic [3:0]        dig_o;
    logic [7:0]        g_h;
    logic [7:0]        g_t;
    logic [7:0]        g_o;
    logic [1:0]        pos;
    logic [DIGIT_COUNT-1:0][7:0] num_seg;
    logic [DIGIT_COUNT-1:0][7:0] txt_seg;
    logic [DIGIT_COUNT-1:0][7:0] seg;

    function automatic logic [7:0] char_glyph(input logic [7:0] ch);
        logic [7:0] off;
        logic [7:0] g;
        off = ch - CHAR_GLYPH_BASE;
        if (ch >= CHAR_A && ch <= CHAR_L) begin
            g = glyph_of(off[4:0]);
        end else if (ch == CHAR_SPACE) begin
            g = SEG_BLANK;
        end else begin
            g = SEG_DASH;
        end
        return g;
    endfunction

    always_comb begin
        unique case (r_item.command) inside
            CMD_INIT, CMD_NUMBER, CMD_TEXT: cmd_known = 1'b1;
            default:                        cmd_known = 1'b0;
        endcase
    end

    assign advance = r_valid && (i_frame_free || !cmd_known);
    assign o_ready = !r_valid || advance;
    assign o_load  = r_valid && i_frame_free && cmd_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    // Saturate, then split the magnitude into decimal digits by reciprocal multiplication.
    always_comb begin
        if (r_item.value > NUM_LIMIT) begin
            v_sat = NUM_LIMIT;
        end else if (r_item.value < -NUM_LIMIT) begin
            v_sat = -NUM_LIMIT;
        end else begin
            v_sat = r_item.value;
        end
        v_neg  = -v_sat;
        neg    = v_sat[15];
        mag    = neg ? v_neg[9:0] : v_sat[9:0];
        h_prod = {6'd0, mag} * 16'd41;
        dig_h  = h_prod[15:12];
        rem10  = mag - ({6'd0, dig_h} * 10'd100);
        rem    = rem10[6:0];
        t_prod = {7'd0, rem} * 14'd103;
        dig_t  = t_prod[13:10];
        one7   = rem - ({3'd0, dig_t} * 7'd10);
        dig_o  = one7[3:0];
        g_h    = glyph_of({1'b0, dig_h});
        g_t    = glyph_of({1'b0, dig_t});
        g_o    = glyph_of({1'b0, dig_o});
    end

    always_comb begin
        num_seg = '{default: SEG_BLANK};
        pos     = {1'b0, neg};
        if (neg) begin
            num_seg[0] = SEG_DASH;
        end
        if (mag >= 10'd100) begin
            num_seg[pos]         = g_h;
            num_seg[pos + 2'd1]  = g_t;
            num_seg[pos + 2'd2]  = g_o;
        end else if (mag >= 10'd10) begin
            num_seg[pos]         = g_t;
            num_seg[pos + 2'd1]  = g_o;
        end else begin
            num_seg[pos]         = g_o;
        end
    end

    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            txt_seg[i] = char_glyph(r_item.chars[i]);
        end
    end

    always_comb begin
        seg          = (r_item.command == CMD_NUMBER) ? num_seg : txt_seg;
        o_frame.init = (r_item.command == CMD_INIT);
        if (o_frame.init) begin
            o_frame.data    = '{default: SEG_BLANK};
            o_frame.data[0] = BYTE_DISPLAY_OFF;
            o_frame.data[1] = BYTE_WRITE_AUTO;
            o_frame.data[2] = BYTE_DISPLAY_ON;
        end else begin
            o_frame.data[0] = BYTE_ADDR_START;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                o_frame.data[i + 1] = seg[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssdfb_serializer.sv =====
`default_nettype none

module ssdfb_serializer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire ssdfb_pkg::t_frame    i_frame,
    output logic                      o_free,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_byte,
    output logic                      o_begin,
    output logic                      o_end,
    output logic                      o_last
);
    import ssdfb_pkg::*;

    localparam logic [IDX_W-1:0] LAST_FRAME_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_INIT_IDX  = IDX_W'(2);

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    t_frame            r_frame;
    logic [IDX_W-1:0]  last_idx;
    logic              take;

    assign last_idx = r_frame.init ? LAST_INIT_IDX : LAST_FRAME_IDX;
    assign take     = r_valid && i_ready;
    assign o_last   = (r_idx == last_idx);
    assign o_free   = !r_valid || (take && o_last);
    assign o_valid  = r_valid;
    assign o_byte   = r_frame.data[r_idx];
    assign o_begin  = r_frame.init || (r_idx == '0);
    assign o_end    = r_frame.init || (r_idx == LAST_FRAME_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx <= last_idx)
        else $error("Word index beyond end of frame.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || (take && o_last)))
        else $error("Frame loaded over one still being sent.");

    a_empty_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && o_last && !i_load) |=> !r_valid)
        else $error("Serialiser still busy after its last word.");

    a_restart_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_idx == '0))
        else $error("New frame does not start at its first word.");
`endif

endmodule

`default_nettype wire

// ===== tb/ssdfb_scoreboard_pkg.sv =====
`default_nettype none

package ssdfb_scoreboard_pkg;

    import ssdfb_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_begin;
        logic       frame_end;
        logic       last;
    } t_frame_word;

    class frame_scoreboard;
        t_frame_word expected_words[$];
        int          errors;
        int          words_checked;
        int          cmd_count[4];
        logic [7:0]  segment_rom[22];

        function new();
            segment_rom = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                            8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
                            8'h76, 8'h38, 8'h37, 8'h3E, 8'h73, 8'h5C};
            errors        = 0;
            words_checked = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
        endfunction

        function logic [DIGIT_COUNT-1:0][7:0] number_segments(logic signed [15:0] value);
            logic [DIGIT_COUNT-1:0][7:0] segs;
            int clipped;
            int mag;
            int n;
            segs    = '0;
            n       = 0;
            clipped = value;
            if (clipped > int'(NUM_LIMIT)) begin
                clipped = int'(NUM_LIMIT);
            end
            if (clipped < -int'(NUM_LIMIT)) begin
                clipped = -int'(NUM_LIMIT);
            end
            if (clipped < 0) begin
                segs[n] = SEG_DASH;
                n++;
                mag = -clipped;
            end else begin
                mag = clipped;
            end
            if (mag >= 100) begin
                segs[n]     = segment_rom[mag / 100];
                segs[n + 1] = segment_rom[(mag / 10) % 10];
                segs[n + 2] = segment_rom[mag % 10];
            end else if (mag >= 10) begin
                segs[n]     = segment_rom[mag / 10];
                segs[n + 1] = segment_rom[mag % 10];
            end else begin
                segs[n] = segment_rom[mag];
            end
            return segs;
        endfunction

        function logic [7:0] char_segment(logic [7:0] ch);
            if (ch >= CHAR_A && ch <= CHAR_L) begin
                return segment_rom[ch - CHAR_GLYPH_BASE];
            end
            if (ch == CHAR_SPACE) begin
                return SEG_BLANK;
            end
            return SEG_DASH;
        endfunction

        function void note_command(logic [1:0] cmd, logic [47:0] data);
            logic [DIGIT_COUNT-1:0][7:0] segs;
            cmd_count[cmd]++;
            case (cmd) inside
                CMD_INIT: begin
                    expected_words.push_back('{BYTE_DISPLAY_OFF, 1'b1, 1'b1, 1'b0});
                    expected_words.push_back('{BYTE_WRITE_AUTO, 1'b1, 1'b1, 1'b0});
                    expected_words.push_back('{BYTE_DISPLAY_ON, 1'b1, 1'b1, 1'b1});
                end
                CMD_NUMBER, CMD_TEXT: begin
                    if (cmd == CMD_NUMBER) begin
                        segs = number_segments(data[15:0]);
                    end else begin
                        for (int i = 0; i < DIGIT_COUNT; i++) begin
                            segs[i] = char_segment(data[16 + 8 * i +: 8]);
                        end
                    end
                    expected_words.push_back('{BYTE_ADDR_START, 1'b1, 1'b0, 1'b0});
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        expected_words.push_back('{segs[i], 1'b0, i == DIGIT_COUNT - 1,
                                                   i == DIGIT_COUNT - 1});
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report(string msg);
            if (errors < 30) begin
                $display("ERROR: %s", msg);
            end
            errors++;
        endtask

        task check_word(logic [7:0] frame_byte, logic [1:0] user, logic last);
            t_frame_word want;
            words_checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("word %02h arrived with nothing outstanding", frame_byte));
                return;
            end
            want = expected_words.pop_front();
            if (frame_byte !== want.frame_byte) begin
                report($sformatf("word %0d: byte %02h, wanted %02h", words_checked,
                                 frame_byte, want.frame_byte));
            end
            if (user[0] !== want.frame_begin) begin
                report($sformatf("word %0d: begin flag %b, wanted %b", words_checked,
                                 user[0], want.frame_begin));
            end
            if (user[1] !== want.frame_end) begin
                report($sformatf("word %0d: end flag %b, wanted %b", words_checked,
                                 user[1], want.frame_end));
            end
            if (last !== want.last) begin
                report($sformatf("word %0d: tlast %b, wanted %b", words_checked,
                                 last, want.last));
            end
        endtask
    endclass

endpackage

`default_nettype wire

// ===== tb/tb_seven_segment_display_frame_builder_core.sv =====
`default_nettype none

module tb_seven_segment_display_frame_builder_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ssdfb_pkg::*;
    import ssdfb_scoreboard_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [47:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    logic        steady = 1'b0;
    int          cycles = 0;

    frame_scoreboard board = new();

    int          directed_values[16] = '{0, 9, 10, 99, 100, 999, 1000, 32767,
                                         -1, -9, -10, -99, -100, -999, -1000, -32768};
    logic [31:0] directed_text[5] = '{"ABCD", "EFGH", "IJKL", 32'h20404D00, 32'hFF7F8020};

    seven_segment_display_frame_builder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            board.note_command(i_s_axis_tuser, i_s_axis_tdata);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_word(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    task automatic send_command(input logic [1:0] cmd, input logic signed [15:0] value,
                                input logic [31:0] chars);
        while (!steady && $urandom_range(0, 99) < 24) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {chars[7:0], chars[15:8], chars[23:16], chars[31:24], value};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 8'(CHAR_A + $urandom_range(0, 11));
        end
        if (pick < 70) begin
            return CHAR_SPACE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [15:0] random_value();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 999));
            1:       return 16'(-int'($urandom_range(0, 999)));
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 20)) - 10);
        endcase
    endfunction

    initial begin
        int          shown;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] chars;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(CMD_INIT, random_value(), $urandom);
        foreach (directed_values[i]) begin
            send_command(CMD_NUMBER, 16'(directed_values[i]), $urandom);
        end
        foreach (directed_text[i]) begin
            send_command(CMD_TEXT, random_value(), directed_text[i]);
        end
        send_command(CMD_UNUSED, random_value(), $urandom);
        send_command(CMD_INIT, random_value(), $urandom);

        shown = 0;
        while (shown < 70) begin
            steady = (shown >= 30 && shown < 60);
            pick   = $urandom_range(0, 99);
            if (pick < 10) begin
                cmd = CMD_INIT;
            end else if (pick < 50) begin
                cmd = CMD_NUMBER;
            end else if (pick < 90) begin
                cmd = CMD_TEXT;
            end else begin
                cmd = CMD_UNUSED;
            end
            chars = {random_char(), random_char(), random_char(), random_char()};
            send_command(cmd, random_value(), chars);
            if (cmd != CMD_UNUSED) begin
                shown++;
            end
        end
        steady = 1'b0;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (board.expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Commands sent: %0d init, %0d number, %0d text, %0d unused code.",
                 board.cmd_count[CMD_INIT], board.cmd_count[CMD_NUMBER],
                 board.cmd_count[CMD_TEXT], board.cmd_count[CMD_UNUSED]);
        $display("Frame words checked: %0d, mismatches: %0d.", board.words_checked,
                 board.errors);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
